[rtl/core/assert_macros.svh]
// Assertion helpers used by the kqt_dp datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define KQT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("keyed quantity table assertion failed");

`define KQT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyed quantity table implication failed");

`define KQT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed quantity table sequence failed");

`else

`define KQT_ASSERT(label, clk, rst_n, prop)

`define KQT_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define KQT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/kqt_pkg.sv]
package kqt_pkg;

  localparam int CAPACITY_DEF = 128;

  localparam int ACT_W     = 2;
  localparam int KEY_W     = 32;
  localparam int AMT_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int IDX_OUT_W = 7;
  localparam int CNT_OUT_W = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_QUERY  = 2'd3
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_MOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic capture;
    logic rd_last;
    logic move;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic match;
    logic scan_more;
    logic cmp_vld;
    logic is_delete;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/kqt_ctrl.sv]
module kqt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kqt_pkg::dp_sts_t  sts,
  output kqt_pkg::dp_cmd_t  cmd
);
  import kqt_pkg::*;

  state_t st_r;
  state_t st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_ready = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          st_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = sts.scan_more && !sts.match;
        if (sts.match) begin
          cmd.capture = 1'b1;
          st_nxt      = sts.is_delete ? S_LAST : S_DONE;
        end else if (!sts.scan_more && !sts.cmp_vld) begin
          st_nxt = S_DONE;
        end
      end
      S_LAST: begin
        cmd.rd_last = 1'b1;
        st_nxt      = S_MOVE;
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        st_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          st_nxt     = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/kqt_dp.sv]
`include "assert_macros.svh"

module kqt_dp #(
  parameter int CAPACITY = kqt_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kqt_pkg::dp_cmd_t               cmd,
  output kqt_pkg::dp_sts_t               sts,
  input  logic [kqt_pkg::ACT_W-1:0]      in_action,
  input  logic [kqt_pkg::KEY_W-1:0]      in_key,
  input  logic signed [kqt_pkg::AMT_W-1:0] in_amount,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kqt_pkg::STATUS_W-1:0]   out_status,
  output logic signed [kqt_pkg::AMT_W-1:0] out_found_amount,
  output logic [kqt_pkg::IDX_OUT_W-1:0]  out_entry_index,
  output logic [kqt_pkg::CNT_OUT_W-1:0]  out_entry_count
);
  import kqt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [AMT_W-1:0] amt_mem [CAPACITY];

  act_t             action_r;
  logic [KEY_W-1:0] key_r;
  logic [AMT_W-1:0] amount_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [KEY_W-1:0] key_rd_r;
  logic [AMT_W-1:0] amt_rd_r;
  logic             hit_r;
  logic [IDX_W-1:0] slot_r;
  logic [AMT_W-1:0] old_amt_r;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [AMT_W-1:0] out_found_r;
  logic [IDX_OUT_W-1:0] out_index_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  logic [CNT_W-1:0] last_cnt;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             add_ok;
  logic             add_full;
  logic             key_we;
  logic             amt_we;
  logic [KEY_W-1:0] key_wdata;
  logic [AMT_W-1:0] amt_wdata;
  logic [CNT_W-1:0] cnt_after;
  status_t          status_res;
  logic [AMT_W-1:0] found_res;
  logic [IDX_W-1:0] index_res;

  assign last_cnt = count_r - 1'b1;
  assign rd_addr  = cmd.rd_last ? last_cnt[IDX_W-1:0] : scan_r[IDX_W-1:0];

  assign add_ok   = (action_r == ACT_ADD) && !hit_r && (count_r != CAP_CNT);
  assign add_full = (action_r == ACT_ADD) && !hit_r && (count_r == CAP_CNT);

  assign wr_addr   = cmd.move ? slot_r :
                     ((action_r == ACT_ADD) ? count_r[IDX_W-1:0] : slot_r);
  assign key_we    = cmd.move || (cmd.finish && add_ok);
  assign amt_we    = key_we || (cmd.finish && (action_r == ACT_UPDATE) && hit_r);
  assign key_wdata = cmd.move ? key_rd_r : key_r;
  assign amt_wdata = cmd.move ? amt_rd_r : amount_r;

  assign cnt_after = add_ok ? count_r + 1'b1 : count_r;

  always_comb begin
    status_res = ST_OK;
    found_res  = '0;
    index_res  = '0;
    if (action_r == ACT_ADD) begin
      if (hit_r) begin
        status_res = ST_PRESENT;
        index_res  = slot_r;
      end else if (add_full) begin
        status_res = ST_FULL;
      end else begin
        index_res = count_r[IDX_W-1:0];
      end
    end else if (hit_r) begin
      index_res = slot_r;
      if (action_r != ACT_DELETE) begin
        found_res = old_amt_r;
      end
    end else begin
      status_res = ST_NOT_FOUND;
    end
  end

  assign sts.match     = cmp_vld_r && (key_rd_r == key_r);
  assign sts.scan_more = scan_r < count_r;
  assign sts.cmp_vld   = cmp_vld_r;
  assign sts.is_delete = (action_r == ACT_DELETE);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_wdata;
    end
    if (amt_we) begin
      amt_mem[wr_addr] <= amt_wdata;
    end
    if (cmd.issue || cmd.rd_last) begin
      key_rd_r <= key_mem[rd_addr];
      amt_rd_r <= amt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.issue;
      if (cmd.move) begin
        count_r <= last_cnt;
      end else if (cmd.finish) begin
        count_r <= cnt_after;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= act_t'(in_action);
      key_r    <= in_key;
      amount_r <= in_amount;
      scan_r   <= '0;
      hit_r    <= 1'b0;
    end else begin
      if (cmd.issue) begin
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.capture) begin
        hit_r     <= 1'b1;
        slot_r    <= cmp_idx_r;
        old_amt_r <= amt_rd_r;
      end
    end
    if (cmd.issue) begin
      cmp_idx_r <= scan_r[IDX_W-1:0];
    end
    if (cmd.finish) begin
      out_status_r <= status_res;
      out_found_r  <= found_res;
      out_index_r  <= IDX_OUT_W'(index_res);
      out_count_r  <= CNT_OUT_W'(cnt_after);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_amount = out_found_r;
  assign out_entry_index  = out_index_r;
  assign out_entry_count  = out_count_r;

  `KQT_ASSERT(a_count_bound, clk, rst_n, count_r <= CAP_CNT)
  `KQT_ASSERT_IMPL(a_issue_in_range, clk, rst_n, cmd.issue, scan_r < count_r)
  `KQT_ASSERT_IMPL(a_finish_slot_free, clk, rst_n, cmd.finish, !out_valid_r || out_ready)
  `KQT_ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd.finish, out_valid_r)
  `KQT_ASSERT_IMPL(a_move_needs_hit, clk, rst_n, cmd.move, hit_r && (count_r != '0))

endmodule

[rtl/core/keyed_quantity_table.sv]
// Each request scans the stored keys in slot order, one read of the key and amount memories
// per cycle. A hit ends the scan, and a delete that hits then reads the last entry and moves
// it into the freed slot; the result is held back while the output stalls. One request is
// in work at a time; the next is taken in the same cycle as the result appears, even while
// it waits. Synchronous active-low reset empties the table and drops any pending result.
module keyed_quantity_table #(
  parameter int CAPACITY = kqt_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [kqt_pkg::ACT_W-1:0]        in_action,
  input  logic [kqt_pkg::KEY_W-1:0]        in_key,
  input  logic signed [kqt_pkg::AMT_W-1:0] in_amount,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [kqt_pkg::STATUS_W-1:0]     out_status,
  output logic signed [kqt_pkg::AMT_W-1:0] out_found_amount,
  output logic [kqt_pkg::IDX_OUT_W-1:0]    out_entry_index,
  output logic [kqt_pkg::CNT_OUT_W-1:0]    out_entry_count
);
  import kqt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  kqt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kqt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_key           (in_key),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found_amount (out_found_amount),
    .out_entry_index  (out_entry_index),
    .out_entry_count  (out_entry_count)
  );

endmodule
